[rtl/core/fbfla_pkg.sv]
// ----------------------------------------------------------------------------
// fbfla_pkg
// shared types and constants of the fixed block free list allocator
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int MaxBlocks  = 255;
  localparam int IdxW       = 8;
  localparam int AddrW      = 32;
  localparam int BsizeW     = 16;
  localparam int CsizeW     = 24;
  localparam int QDepth     = 2;
  localparam int PAddrW     = 4;

  localparam logic [PAddrW-1:0] RegBase  = 4'h0;
  localparam logic [PAddrW-1:0] RegBsize = 4'h4;
  localparam logic [PAddrW-1:0] RegCsize = 4'h8;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_OWNS    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_NOT_OWNED  = 2'd2,
    ST_FULLY_FREE = 2'd3
  } status_t;

  // classified word passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic              owned;
    logic [IdxW-1:0]   idx;
    logic [IdxW-1:0]   init_count;
  } job_t;

  typedef struct packed {
    logic [AddrW-1:0] block_address;
    logic [IdxW-1:0]  block_index;
    status_t          status;
    logic             owned;
    logic [IdxW-1:0]  free_count;
    logic [IdxW-1:0]  used_count;
    logic             all_free;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_MUL,
    B_DONE
  } back_state_t;

endpackage

[rtl/core/fbfla_ram.sv]
// ----------------------------------------------------------------------------
// fbfla_ram
// generic single write, single read RAM with registered read
// ----------------------------------------------------------------------------
module fbfla_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/fbfla_front.sv]
// ----------------------------------------------------------------------------
// fbfla_front
// accepts command words, runs the ownership and init divisions serially
// ----------------------------------------------------------------------------
module fbfla_front import fbfla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd,
  input  logic [AddrW-1:0]  address,
  input  logic [AddrW-1:0]  base_address,
  input  logic [BsizeW-1:0] blk_bytes,
  input  logic [CsizeW-1:0] region_bytes,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job
);

  localparam int CntW = $clog2(AddrW + 1);

  front_state_t state, state_next;
  cmd_t             cmd_q;
  logic [AddrW-1:0] quot;
  logic [BsizeW:0]  rem;
  logic [CntW-1:0]  cnt;
  logic [AddrW-1:0] dividend;
  logic [BsizeW:0]  trial;
  logic             sub_ok;
  logic             owned_w;
  logic [IdxW-1:0]  count_w;

  assign dividend = (cmd == CMD_INIT) ? {{(AddrW-CsizeW){1'b0}}, region_bytes}
                                      : address - base_address;
  assign trial  = {rem[BsizeW-1:0], quot[AddrW-1]};
  assign sub_ok = trial >= {1'b0, blk_bytes};

  // remainder zero and quotient fits an index, block count checked in the back
  assign owned_w = (blk_bytes != '0) && (rem == '0) &&
                   (quot[AddrW-1:IdxW] == '0);
  assign count_w = (blk_bytes == '0) ? '0 :
                   (quot > AddrW'(MaxBlocks)) ? IdxW'(MaxBlocks) : quot[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      cmd_q <= cmd_t'(cmd);
      quot  <= dividend;
      rem   <= '0;
      cnt   <= CntW'(AddrW);
    end else if (state == F_DIV) begin
      quot <= {quot[AddrW-2:0], sub_ok};
      rem  <= sub_ok ? trial - {1'b0, blk_bytes} : trial;
      cnt  <= cnt - 1'b1;
    end
  end

  always_comb begin
    state_next     = state;
    full           = 1'b1;
    job_valid      = 1'b0;
    job.cmd        = cmd_q;
    job.owned      = owned_w;
    job.idx        = quot[IdxW-1:0];
    job.init_count = count_w;
    case (state)
      F_IDLE: begin
        full = 1'b0;
        if (push) begin
          state_next = (cmd_t'(cmd) == CMD_ACQUIRE) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (cnt == CntW'(1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    state == F_DIV |-> full) else $error("front accepts while dividing");
  a_push_div: assert property (@(posedge clk) disable iff (rst)
    (state == F_IDLE && push && cmd != CMD_ACQUIRE) |=> state == F_DIV)
    else $error("division not started");
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |=> job_valid && $stable(job))
    else $error("job word changed while stalled");

endmodule

[rtl/core/fbfla_queue.sv]
// ----------------------------------------------------------------------------
// fbfla_queue
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
module fbfla_queue import fbfla_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  localparam int PtrW = $clog2(QDepth);

  job_t            slot [QDepth];
  logic [PtrW-1:0] wptr, rptr;
  logic [PtrW:0]   count;
  logic            wr, rd;

  assign in_ready  = count != (PtrW+1)'(QDepth);
  assign out_valid = count != '0;
  assign out_job   = slot[rptr];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wptr] <= in_job;
    end
  end

  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PtrW+1)'(QDepth)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> count == $past(count) + 1'b1) else $error("count slip");
  a_cnt_dn: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> count == $past(count) - 1'b1) else $error("count slip");

endmodule

[rtl/core/fbfla_back.sv]
// ----------------------------------------------------------------------------
// fbfla_back
// free list state, link memory and result register
// ----------------------------------------------------------------------------
module fbfla_back import fbfla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  input  logic [AddrW-1:0]  base_address,
  input  logic [BsizeW-1:0] blk_bytes,
  output logic              res_valid,
  input  logic              res_pop,
  output result_t           res
);

  back_state_t state, state_next;
  logic [IdxW-1:0] free_head, available_count, never_used_mark;
  logic [IdxW-1:0] total_blocks;
  job_t            cur;
  logic [IdxW-1:0] link_rdata;
  logic            link_we;
  logic [AddrW-1:0] prod;
  status_t         st;
  logic [IdxW-1:0] ridx;
  logic            take;
  logic            apply;
  logic            own_ok;
  logic [AddrW-1:0] res_addr;
  logic [IdxW-1:0]  res_idx;
  status_t          res_st;
  logic             res_own;

  assign take = job_valid && state == B_IDLE && !res_valid;
  assign job_ready = take;

  // aligned block start whose index lies below the current block count
  assign own_ok = cur.owned && (cur.idx < total_blocks);

  fbfla_ram #(.Width(IdxW), .Depth(MaxBlocks + 1)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (cur.idx),
    .wdata (free_head),
    .raddr (free_head),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    apply      = 1'b0;
    link_we    = 1'b0;
    st         = ST_OK;
    ridx       = '0;
    case (cur.cmd)
      CMD_ACQUIRE: begin
        if (available_count == '0) st = ST_NO_FREE;
        else ridx = free_head;
      end
      CMD_RELEASE: begin
        if (!own_ok) st = ST_NOT_OWNED;
        else if (available_count >= total_blocks) st = ST_FULLY_FREE;
        else ridx = cur.idx;
      end
      default: ;
    endcase
    case (state)
      B_IDLE: if (take) state_next = B_READ;
      B_READ: state_next = B_MUL;
      B_MUL:  state_next = B_DONE;
      B_DONE: begin
        apply      = 1'b1;
        link_we    = cur.cmd == CMD_RELEASE && st == ST_OK;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) cur <= job;
    if (state == B_READ) prod <= AddrW'(free_head) * AddrW'(blk_bytes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head       <= '0;
      available_count <= '0;
      total_blocks    <= '0;
      never_used_mark <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (res_valid && res_pop) res_valid <= 1'b0;
      if (apply) begin
        res_valid <= 1'b1;
        case (cur.cmd)
          CMD_INIT: begin
            total_blocks    <= cur.init_count;
            available_count <= cur.init_count;
            free_head       <= '0;
            never_used_mark <= '0;
          end
          CMD_ACQUIRE: begin
            if (st == ST_OK) begin
              if (free_head == never_used_mark) begin
                free_head       <= free_head + 1'b1;
                never_used_mark <= never_used_mark + 1'b1;
              end else begin
                free_head <= link_rdata;
              end
              available_count <= available_count - 1'b1;
            end
          end
          CMD_RELEASE: begin
            if (st == ST_OK) begin
              free_head       <= cur.idx;
              available_count <= available_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      res_addr <= (cur.cmd == CMD_ACQUIRE && st == ST_OK) ?
                  base_address + prod : '0;
      res_idx  <= ridx;
      res_st   <= st;
      res_own  <= (cur.cmd == CMD_RELEASE || cur.cmd == CMD_OWNS) && own_ok;
    end
  end

  always_comb begin
    res.block_address = res_addr;
    res.block_index   = res_idx;
    res.status        = res_st;
    res.owned         = res_own;
    res.free_count    = available_count;
    res.used_count    = total_blocks - available_count;
    res.all_free      = available_count >= total_blocks;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    apply |-> !res_valid) else $error("result overwritten");
  a_avail: assert property (@(posedge clk) disable iff (rst)
    available_count <= total_blocks) else $error("free count above total");
  a_take: assert property (@(posedge clk) disable iff (rst)
    take |=> state == B_READ) else $error("back did not start");

endmodule

[rtl/core/fixed_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Allocator of equal-size blocks in one chunk, managed through a free list
// of block indexes. For each init, release or ownership word the front part
// accepts it, runs a 32-step serial divider and then hands the word on;
// an acquire word skips the divider. The back part takes each word through
// its read, multiply and done states for the link memory read and the
// address multiply, and takes no new word until the result register is popped.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator import fbfla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd,
  input  logic [AddrW-1:0]  address,
  output logic              empty,
  input  logic              pop,
  output logic [AddrW-1:0]  block_address,
  output logic [IdxW-1:0]   block_index,
  output logic [1:0]        status,
  output logic              owned,
  output logic [IdxW-1:0]   free_count,
  output logic [IdxW-1:0]   used_count,
  output logic              all_free,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [AddrW-1:0]  base_address;
  logic [BsizeW-1:0] blk_bytes;
  logic [CsizeW-1:0] region_bytes;
  logic    fj_valid, fj_ready, bj_valid, bj_ready, res_valid;
  job_t    fjob, bjob;
  result_t res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      blk_bytes    <= BsizeW'(16);
      region_bytes <= CsizeW'(4080);
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegBase:  base_address <= pwdata;
        RegBsize: blk_bytes    <= pwdata[BsizeW-1:0];
        RegCsize: region_bytes <= pwdata[CsizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegBase:  prdata = base_address;
      RegBsize: prdata = {{(32-BsizeW){1'b0}}, blk_bytes};
      RegCsize: prdata = {{(32-CsizeW){1'b0}}, region_bytes};
      default:  prdata = '0;
    endcase
  end

  fbfla_front u_front (
    .clk, .rst, .push, .full, .cmd, .address,
    .base_address, .blk_bytes, .region_bytes,
    .job_valid (fj_valid), .job_ready (fj_ready), .job (fjob)
  );

  fbfla_queue u_queue (
    .clk, .rst,
    .in_valid (fj_valid), .in_ready (fj_ready), .in_job (fjob),
    .out_valid (bj_valid), .out_ready (bj_ready), .out_job (bjob)
  );

  fbfla_back u_back (
    .clk, .rst,
    .job_valid (bj_valid), .job_ready (bj_ready), .job (bjob),
    .base_address, .blk_bytes,
    .res_valid, .res_pop (pop), .res
  );

  assign empty         = !res_valid;
  assign block_address = res.block_address;
  assign block_index   = res.block_index;
  assign status        = res.status;
  assign owned         = res.owned;
  assign free_count    = res.free_count;
  assign used_count    = res.used_count;
  assign all_free      = res.all_free;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Exercises the fixed block free list allocator through its command queue
// and register port. A local model of the free list predicts every result
// word, which is checked field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import fbfla_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        cmd = CMD_INIT;
  logic [AddrW-1:0]  address = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [AddrW-1:0]  block_address;
  logic [IdxW-1:0]   block_index;
  logic [1:0]        status;
  logic              owned;
  logic [IdxW-1:0]   free_count;
  logic [IdxW-1:0]   used_count;
  logic              all_free;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PAddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  fixed_block_free_list_allocator DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator shadow state
  logic [AddrW-1:0]  m_base = '0;
  logic [BsizeW-1:0] m_bsize = 16;
  logic [CsizeW-1:0] m_csize = 4080;
  logic [IdxW-1:0]   m_link [MaxBlocks];
  logic [IdxW-1:0]   m_head = '0;
  logic [IdxW-1:0]   m_avail = '0;
  logic [IdxW-1:0]   m_total = '0;
  logic [IdxW-1:0]   m_mark = '0;
  logic [IdxW-1:0]   held_q [$];   // indexes currently acquired

  result_t expected_q [$];
  int errors = 0;
  int n_words = 0;
  int n_results = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  function automatic bit owns_addr(input logic [AddrW-1:0] a, output logic [IdxW-1:0] idx);
    logic [AddrW-1:0] off;
    longint unsigned span;
    off = a - m_base;
    idx = '0;
    if (m_bsize == 0) return 1'b0;
    span = longint'(m_bsize) * m_total;
    if (off >= span) return 1'b0;
    if (off % m_bsize != 0) return 1'b0;
    idx = IdxW'(off / m_bsize);
    return 1'b1;
  endfunction

  function automatic result_t allocate_step(input cmd_t c, input logic [AddrW-1:0] a);
    result_t r;
    logic [IdxW-1:0] idx;
    int n;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_INIT: begin
        n = (m_bsize == 0) ? 0 : int'(m_csize / m_bsize);
        if (n > MaxBlocks) n = MaxBlocks;
        m_total = IdxW'(n);
        m_avail = m_total;
        m_head = '0;
        m_mark = '0;
      end
      CMD_ACQUIRE: begin
        if (m_avail == 0) r.status = ST_NO_FREE;
        else begin
          idx = m_head;
          if (idx == m_mark) begin
            m_head = idx + 1'b1;
            m_mark = m_mark + 1'b1;
          end else if (idx < MaxBlocks) m_head = m_link[idx];
          else m_head = '0;
          m_avail = m_avail - 1'b1;
          r.block_index = idx;
          r.block_address = m_base + AddrW'(idx) * AddrW'(m_bsize);
        end
      end
      CMD_RELEASE: begin
        if (!owns_addr(a, idx)) r.status = ST_NOT_OWNED;
        else begin
          r.owned = 1'b1;
          if (m_avail >= m_total) r.status = ST_FULLY_FREE;
          else begin
            m_link[idx] = m_head;
            m_head = idx;
            m_avail = m_avail + 1'b1;
            r.block_index = idx;
          end
        end
      end
      default: r.owned = owns_addr(a, idx);
    endcase
    r.free_count = m_avail;
    r.used_count = m_total - m_avail;
    r.all_free = (m_avail >= m_total);
    return r;
  endfunction

  // one word into the command queue, idling before it at random
  task automatic send_word(input cmd_t c, input logic [AddrW-1:0] a);
    if (!quiet && $urandom_range(3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    address <= a;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q.push_back(allocate_step(c, a));
    n_words++;
  endtask

  // records the index that an acquire will take, so only held blocks are released
  task automatic acquire_word();
    logic [IdxW-1:0] i;
    i = m_head;
    if (m_avail != 0) held_q.push_back(i);
    send_word(CMD_ACQUIRE, 0);
  endtask

  task automatic release_held(input int pick);
    logic [IdxW-1:0] i;
    i = held_q[pick];
    held_q.delete(pick);
    send_word(CMD_RELEASE, m_base + AddrW'(i) * AddrW'(m_bsize));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PAddrW-1:0] a, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (a)
      RegBase: m_base = d;
      RegBsize: m_bsize = d[BsizeW-1:0];
      default: m_csize = d[CsizeW-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic setup(input logic [31:0] b, input logic [31:0] bs, input logic [31:0] cs);
    drain();
    write_reg(RegBase, b);
    write_reg(RegBsize, bs);
    write_reg(RegCsize, cs);
    held_q.delete();
    send_word(CMD_INIT, 0);
  endtask

  task automatic test_before_init();
    send_word(CMD_ACQUIRE, 0);
    send_word(CMD_RELEASE, 0);
    send_word(CMD_OWNS, 0);
  endtask

  task automatic test_directed();
    setup(32'hFFFF_FFF0, 16, 64);      // address wrap, four blocks
    for (int k = 0; k < 5; k++) acquire_word();   // last one finds no block
    send_word(CMD_OWNS, 32'h0000_0000);
    send_word(CMD_OWNS, 32'h0000_0001);
    send_word(CMD_OWNS, 32'h0000_0030);
    send_word(CMD_RELEASE, 32'hFFFF_FFF8);         // misaligned
    send_word(CMD_RELEASE, 32'h0000_0030);         // past the end
    release_held(1);
    release_held(0);
    acquire_word();
    while (held_q.size() != 0) release_held(0);
    send_word(CMD_RELEASE, 32'hFFFF_FFF0);         // already fully free
    setup(32'h1234_5678, 0, 24'hFFFFFF);           // zero block size
    send_word(CMD_ACQUIRE, 0);
    send_word(CMD_OWNS, 32'h1234_5678);
    setup(0, 16'hFFFF, 24'hFFFFFF);                // largest sizes, 255 blocks
    acquire_word();
    send_word(CMD_OWNS, 32'hFFFF_FFFF);
    setup(0, 1, 0);                                // empty chunk
    acquire_word();
  endtask

  task automatic random_phase(input int n, input int hi_blocks);
    int r;
    logic [AddrW-1:0] ra;
    logic [IdxW-1:0]  ri;
    setup($urandom, $urandom_range(64, 1), $urandom_range(hi_blocks * 64, 0));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        held_q.delete();
        send_word(CMD_INIT, $urandom);
      end else if (r < 45) acquire_word();
      else if (r < 80 && held_q.size() != 0) release_held($urandom_range(held_q.size() - 1));
      else if (r < 88) begin
        // a random address that hits a block start is only queried
        ra = $urandom;
        if (owns_addr(ra, ri)) send_word(CMD_OWNS, ra);
        else send_word(CMD_RELEASE, ra);
      end
      else if (r < 92 && held_q.size() == 0 && m_total != 0)
        send_word(CMD_RELEASE, m_base + AddrW'($urandom_range(m_total - 1)) * m_bsize);
      else if (r < 96) send_word(CMD_OWNS, $urandom);
      else send_word(CMD_OWNS, m_base + AddrW'($urandom_range(300)) * m_bsize);
    end
  endtask

  task automatic test_random();
    random_phase(150, 8);
    random_phase(150, 300);
    random_phase(150, 3);
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = hold_req + 1;
    for (int k = 0; k < 20; k++) send_word(CMD_OWNS, $urandom);
  endtask

  task automatic test_no_idling();
    drain();
    quiet = 1'b1;
    random_phase(100, 6);
  endtask

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
    end else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // result side: random pops, none during a hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (hold_cnt > 0) pop <= 1'b0;
    else if (!quiet && $urandom_range(5) == 0) pop <= 1'b0;
    else pop <= 1'b1;
    if (!rst && pop && !empty) begin
      n_results <= n_results + 1;
      if (expected_q.size() == 0) begin
        $error("result word with none expected");
        errors <= errors + 1;
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (block_address !== e.block_address) begin
          $error("block_address exp %h got %h", e.block_address, block_address);
          errors <= errors + 1;
        end
        if (block_index !== e.block_index) begin
          $error("block_index exp %0d got %0d", e.block_index, block_index);
          errors <= errors + 1;
        end
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status);
          errors <= errors + 1;
        end
        if (owned !== e.owned) begin
          $error("owned exp %0d got %0d", e.owned, owned);
          errors <= errors + 1;
        end
        if (free_count !== e.free_count) begin
          $error("free_count exp %0d got %0d", e.free_count, free_count);
          errors <= errors + 1;
        end
        if (used_count !== e.used_count) begin
          $error("used_count exp %0d got %0d", e.used_count, used_count);
          errors <= errors + 1;
        end
        if (all_free !== e.all_free) begin
          $error("all_free exp %0d got %0d", e.all_free, all_free);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    foreach (m_link[i]) m_link[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_init();
    test_directed();
    test_random();
    test_backpressure();
    test_no_idling();
    drain();
    $display("covered %0d command words and %0d result words, including", n_words, n_results);
    $display("empty, foreign and fully free cases, wrap, zero size and a full stall");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
